@@ rtl/core/raycast_column_setup_top_assert.svh @@
// ----------------------------------------------------------------------------
// raycast_column_setup_top_assert
// assertion macros for the ray setup block
// ----------------------------------------------------------------------------
`ifndef RAYCAST_COLUMN_SETUP_TOP_ASSERT_SVH
`define RAYCAST_COLUMN_SETUP_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RCS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ray setup check failed");

// next-cycle implication, disabled during reset
`define RCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ray setup check failed");

`endif

@@ rtl/core/rcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rcs_pkg
// shared widths, register indexes and reset values of the ray setup block
// ----------------------------------------------------------------------------
package rcs_pkg;
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = FRAC_BITS + 8;
    localparam int DIR_W     = FRAC_BITS + 2;
    localparam int WIDTH_W   = 13;
    localparam int COL_W     = 12;
    localparam int CELL_W    = 8;
    localparam int DIST_W    = 32;
    localparam int MAX_WIDTH = 4096;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = POS_W;
    // dividend widths of the two divider kinds
    localparam int CAM_DIV_N = COL_W + FRAC_BITS + 1;
    localparam int RCP_DIV_N = 2 * FRAC_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd6;

    localparam logic signed [DIR_W-1:0] ONE_FX    = DIR_W'(1 << FRAC_BITS);
    localparam logic signed [DIR_W-1:0] DIR_MAX   = {1'b0, {(DIR_W-1){1'b1}}};
    localparam logic signed [DIR_W-1:0] DIR_MIN   = {1'b1, {(DIR_W-1){1'b0}}};
    localparam logic signed [DIR_W-1:0] RST_VIEW_X  = 18'sd65536;
    localparam logic signed [DIR_W-1:0] RST_PLANE_Y = 18'sd43254;
    localparam logic [WIDTH_W-1:0]      RST_WIDTH   = 13'd640;
endpackage

@@ rtl/core/rcs_div.sv @@
// ----------------------------------------------------------------------------
// rcs_div
// pipelined restoring divider, one quotient bit per stage, tag carried along
// ----------------------------------------------------------------------------
module rcs_div #(
    parameter int N  = 29,
    parameter int D  = 13,
    parameter int TW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [N-1:0]  dividend,
    input  logic [D-1:0]  divisor,
    input  logic [TW-1:0] tag,
    output logic          out_valid,
    output logic [N-1:0]  quotient,
    output logic [TW-1:0] out_tag
);
    logic [D-1:0]  rem_reg [N];
    logic [N-1:0]  dq_reg  [N];
    logic [D-1:0]  dvs_reg [N];
    logic [TW-1:0] tag_reg [N];
    logic [N-1:0]  vld_reg;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [D-1:0]  rem_in;
        logic [N-1:0]  dq_in;
        logic [D-1:0]  dvs_in;
        logic [TW-1:0] tag_in;
        logic          vld_in;
        logic [D:0]    shifted;
        logic [D:0]    diff;
        logic          ge;
        logic [D-1:0]  rem_next;
        logic [N-1:0]  dq_next;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = dividend;
            assign dvs_in = divisor;
            assign tag_in = tag;
            assign vld_in = in_valid;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign tag_in = tag_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        always_comb begin
            shifted  = {rem_in, dq_in[N-1]};
            diff     = shifted - {1'b0, dvs_in};
            ge       = (shifted >= {1'b0, dvs_in});
            rem_next = ge ? diff[D-1:0] : shifted[D-1:0];
            dq_next  = {dq_in[N-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                dq_reg[k]  <= dq_next;
                dvs_reg[k] <= dvs_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quotient  = dq_reg[N-1];
    assign out_tag   = tag_reg[N-1];
endmodule

@@ rtl/core/raycast_column_setup_top.sv @@
// ----------------------------------------------------------------------------
// raycast_column_setup_top
// per-column ray setup for a grid-walking raycaster
// ----------------------------------------------------------------------------
// One request per screen column goes in and one ray setup comes out, in
// order. The block takes a new column every clock cycle unless a finished
// result is held. The path runs through the two bit-per-stage divider
// pipelines: one for camera_x = 2*column/width - 1 and one pair for the
// reciprocal delta distances. A stall on the result side freezes the whole
// pipeline, so s_ready is low only while a finished result waits.
// Configuration registers are read live and must only be written
// while no request is in flight.
module raycast_column_setup_top
    import rcs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data,
    // column requests
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [COL_W-1:0]           s_column,
    // ray setup results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [DIR_W-1:0]    m_camera_x,
    output logic signed [DIR_W-1:0]    m_ray_dir_x,
    output logic signed [DIR_W-1:0]    m_ray_dir_y,
    output logic [CELL_W-1:0]          m_cell_x,
    output logic [CELL_W-1:0]          m_cell_y,
    output logic                       m_step_x_pos,
    output logic                       m_step_y_pos,
    output logic [DIST_W-1:0]          m_delta_x,
    output logic [DIST_W-1:0]          m_delta_y,
    output logic [DIST_W-1:0]          m_side_x,
    output logic [DIST_W-1:0]          m_side_y
);
    localparam int PROD_W = 2 * DIR_W;
    localparam int SUM_W  = DIR_W + 3;
    localparam int FD_W   = FRAC_BITS + 1;
    localparam int SP_W   = FD_W + DIST_W;

    // configuration registers
    logic [POS_W-1:0]          pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0]   view_x_reg, view_y_reg, plane_x_reg, plane_y_reg;
    logic [WIDTH_W-1:0]        width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            view_x_reg  <= RST_VIEW_X;
            view_y_reg  <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= RST_PLANE_Y;
            width_reg   <= RST_WIDTH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data;
                REG_POS_Y:   pos_y_reg   <= cfg_data;
                REG_VIEW_X:  view_x_reg  <= cfg_data[DIR_W-1:0];
                REG_VIEW_Y:  view_y_reg  <= cfg_data[DIR_W-1:0];
                REG_PLANE_X: plane_x_reg <= cfg_data[DIR_W-1:0];
                REG_PLANE_Y: plane_y_reg <= cfg_data[DIR_W-1:0];
                REG_WIDTH:   width_reg   <= cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipeline moves unless a result is held
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // width clamped to 1..MAX_WIDTH
    logic [WIDTH_W-1:0] width_eff;
    always_comb begin
        if (width_reg == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (width_reg > WIDTH_W'(MAX_WIDTH)) begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
    end

    // camera divider: (2*column << FRAC_BITS) / width
    logic                 cdiv_valid;
    logic [CAM_DIV_N-1:0] cdiv_q;
    logic [0:0]           cdiv_tag;

    rcs_div #(.N(CAM_DIV_N), .D(WIDTH_W), .TW(1)) u_cam_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .dividend  ({s_column, {(FRAC_BITS+1){1'b0}}}),
        .divisor   (width_eff),
        .tag       (1'b0),
        .out_valid (cdiv_valid),
        .quotient  (cdiv_q),
        .out_tag   (cdiv_tag)
    );

    // camera_x, capped at +one
    logic                    v2_reg;
    logic signed [DIR_W-1:0] cam2_reg, cam2_next;
    always_comb begin
        if (cdiv_q > CAM_DIV_N'(2 << FRAC_BITS)) begin
            cam2_next = ONE_FX;
        end else begin
            cam2_next = DIR_W'(cdiv_q) - ONE_FX;
        end
    end

    // plane * camera_x
    logic                     v3_reg;
    logic signed [DIR_W-1:0]  cam3_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg;

    // ray direction with saturation
    logic                     v4_reg;
    logic signed [DIR_W-1:0]  cam4_reg;
    logic signed [DIR_W-1:0]  rdx4_reg, rdy4_reg, rdx4_next, rdy4_next;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic [DIR_W-1:0]         mag_x, mag_y;

    always_comb begin
        sum_x = SUM_W'(view_x_reg) + SUM_W'(px_reg >>> FRAC_BITS);
        sum_y = SUM_W'(view_y_reg) + SUM_W'(py_reg >>> FRAC_BITS);
        if (sum_x > SUM_W'(DIR_MAX)) begin
            rdx4_next = DIR_MAX;
        end else if (sum_x < SUM_W'(DIR_MIN)) begin
            rdx4_next = DIR_MIN;
        end else begin
            rdx4_next = DIR_W'(sum_x);
        end
        if (sum_y > SUM_W'(DIR_MAX)) begin
            rdy4_next = DIR_MAX;
        end else if (sum_y < SUM_W'(DIR_MIN)) begin
            rdy4_next = DIR_MIN;
        end else begin
            rdy4_next = DIR_W'(sum_y);
        end
        // magnitude; the most negative value maps to 2^(DIR_W-1) unsigned
        mag_x = rdx4_reg[DIR_W-1] ? (~rdx4_reg + 1'b1) : rdx4_reg;
        mag_y = rdy4_reg[DIR_W-1] ? (~rdy4_reg + 1'b1) : rdy4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= cdiv_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cam2_reg <= cam2_next;
            cam3_reg <= cam2_reg;
            px_reg   <= plane_x_reg * cam2_reg;
            py_reg   <= plane_y_reg * cam2_reg;
            cam4_reg <= cam3_reg;
            rdx4_reg <= rdx4_next;
            rdy4_reg <= rdy4_next;
        end
    end

    // reciprocal dividers: 2^(2*FRAC_BITS) / |ray_dir|; a zero divisor gives all ones
    logic                   xdiv_valid, ydiv_valid;
    logic [RCP_DIV_N-1:0]   xdiv_q, ydiv_q;
    logic [2*DIR_W-1:0]     xdiv_tag;
    logic [DIR_W-1:0]       ydiv_tag;

    rcs_div #(.N(RCP_DIV_N), .D(DIR_W), .TW(2*DIR_W)) u_rcp_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .dividend  ({1'b1, {(RCP_DIV_N-1){1'b0}}}),
        .divisor   (mag_x),
        .tag       ({cam4_reg, rdx4_reg}),
        .out_valid (xdiv_valid),
        .quotient  (xdiv_q),
        .out_tag   (xdiv_tag)
    );

    rcs_div #(.N(RCP_DIV_N), .D(DIR_W), .TW(DIR_W)) u_rcp_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .dividend  ({1'b1, {(RCP_DIV_N-1){1'b0}}}),
        .divisor   (mag_y),
        .tag       (rdy4_reg),
        .out_valid (ydiv_valid),
        .quotient  (ydiv_q),
        .out_tag   (ydiv_tag)
    );

    // delta saturation and distance to the first grid line
    logic                    v5_reg;
    logic signed [DIR_W-1:0] cam5_reg, rdx5_reg, rdy5_reg;
    logic [DIST_W-1:0]       dx5_reg, dy5_reg;
    logic [FD_W-1:0]         fx5_reg, fy5_reg, fx5_next, fy5_next;
    logic [FD_W-1:0]         frac_x, frac_y;

    always_comb begin
        frac_x = {1'b0, pos_x_reg[FRAC_BITS-1:0]};
        frac_y = {1'b0, pos_y_reg[FRAC_BITS-1:0]};
        // negative ray walks back to the cell's low edge
        fx5_next = xdiv_tag[DIR_W-1] ? frac_x : FD_W'(1 << FRAC_BITS) - frac_x;
        fy5_next = ydiv_tag[DIR_W-1] ? frac_y : FD_W'(1 << FRAC_BITS) - frac_y;
    end

    // side distance product
    logic                    v6_reg;
    logic signed [DIR_W-1:0] cam6_reg, rdx6_reg, rdy6_reg;
    logic [DIST_W-1:0]       dx6_reg, dy6_reg;
    logic [SP_W-1:0]         spx6_reg, spy6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= xdiv_valid;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cam5_reg <= xdiv_tag[2*DIR_W-1:DIR_W];
            rdx5_reg <= xdiv_tag[DIR_W-1:0];
            rdy5_reg <= ydiv_tag;
            dx5_reg  <= xdiv_q[RCP_DIV_N-1] ? '1 : xdiv_q[DIST_W-1:0];
            dy5_reg  <= ydiv_q[RCP_DIV_N-1] ? '1 : ydiv_q[DIST_W-1:0];
            fx5_reg  <= fx5_next;
            fy5_reg  <= fy5_next;
            cam6_reg <= cam5_reg;
            rdx6_reg <= rdx5_reg;
            rdy6_reg <= rdy5_reg;
            dx6_reg  <= dx5_reg;
            dy6_reg  <= dy5_reg;
            spx6_reg <= SP_W'(fx5_reg) * SP_W'(dx5_reg);
            spy6_reg <= SP_W'(fy5_reg) * SP_W'(dy5_reg);
        end
    end

    // output register, also the hold stage while the consumer stalls
    logic [SP_W-FRAC_BITS-1:0] shx, shy;
    assign shx = spx6_reg[SP_W-1:FRAC_BITS];
    assign shy = spy6_reg[SP_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_camera_x   <= cam6_reg;
            m_ray_dir_x  <= rdx6_reg;
            m_ray_dir_y  <= rdy6_reg;
            m_cell_x     <= pos_x_reg[POS_W-1:FRAC_BITS];
            m_cell_y     <= pos_y_reg[POS_W-1:FRAC_BITS];
            m_step_x_pos <= !rdx6_reg[DIR_W-1];
            m_step_y_pos <= !rdy6_reg[DIR_W-1];
            m_delta_x    <= dx6_reg;
            m_delta_y    <= dy6_reg;
            m_side_x     <= (shx[SP_W-FRAC_BITS-1:DIST_W] != '0) ? '1 : shx[DIST_W-1:0];
            m_side_y     <= (shy[SP_W-FRAC_BITS-1:DIST_W] != '0) ? '1 : shy[DIST_W-1:0];
        end
    end

    // checks
`include "raycast_column_setup_top_assert.svh"
    `RCS_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `RCS_ASSERT_NOW(a_cam_range, aclk, aresetn, m_valid,
        (m_camera_x <= ONE_FX) && (m_camera_x >= -ONE_FX))
    `RCS_ASSERT_NOW(a_zero_dir_delta, aclk, aresetn, m_valid && (m_ray_dir_x == '0),
        (m_delta_x == '1) && m_step_x_pos)
    `RCS_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_side_x) && $stable(m_delta_y))
    // both reciprocal pipelines run in lockstep; the camera divider tag is clear
    `RCS_ASSERT_NOW(a_div_lockstep, aclk, aresetn, xdiv_valid, ydiv_valid && !cdiv_tag[0])
endmodule

@@ tb/raycast_column_setup_top_tb.sv @@
// ----------------------------------------------------------------------------
// raycast_column_setup_top_tb
// self-checking bench for the per-column ray setup block
// ----------------------------------------------------------------------------
// Column requests are fed through a valid/ready driver. Every accepted request
// is run through a fixed-point predictor of the ray setup, and the expected
// rays are queued. A monitor compares each accepted ray field by field with
// the oldest expected one. The run goes through several camera and position
// settings, the register extremes among them.
module raycast_column_setup_top_tb;
    import rcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DIR_W-1:0] camera_x;
        logic signed [DIR_W-1:0] ray_dir_x;
        logic signed [DIR_W-1:0] ray_dir_y;
        logic [CELL_W-1:0]       cell_x;
        logic [CELL_W-1:0]       cell_y;
        logic                    step_x_pos;
        logic                    step_y_pos;
        logic [DIST_W-1:0]       delta_x;
        logic [DIST_W-1:0]       delta_y;
        logic [DIST_W-1:0]       side_x;
        logic [DIST_W-1:0]       side_y;
    } ray_setup_t;

    localparam int LATENCY = CAM_DIV_N + RCP_DIV_N + 6;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [COL_W-1:0]        s_column;
    logic                    m_valid;
    logic                    m_ready;
    ray_setup_t              got;
    logic                    s_accepted;
    logic                    m_accepted;

    // shadow copy of the camera registers
    logic [POS_W-1:0]        sh_pos_x, sh_pos_y;
    logic signed [DIR_W-1:0] sh_view_x, sh_view_y, sh_plane_x, sh_plane_y;
    logic [WIDTH_W-1:0]      sh_width;

    logic [COL_W-1:0]        column_queue[$];
    ray_setup_t              expected_rays[$];
    int                      mismatches;
    int                      rays_checked;
    int                      configs_used;
    int                      send_wait;
    int                      recv_wait;

    raycast_column_setup_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_column     (s_column),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_camera_x   (got.camera_x),
        .m_ray_dir_x  (got.ray_dir_x),
        .m_ray_dir_y  (got.ray_dir_y),
        .m_cell_x     (got.cell_x),
        .m_cell_y     (got.cell_y),
        .m_step_x_pos (got.step_x_pos),
        .m_step_y_pos (got.step_y_pos),
        .m_delta_x    (got.delta_x),
        .m_delta_y    (got.delta_y),
        .m_side_x     (got.side_x),
        .m_side_y     (got.side_y)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // one axis: start cell, step sign, reciprocal delta and first side distance
    function automatic void walk_axis(input longint dir, input longint unsigned pos,
                                      output logic [CELL_W-1:0] start_cell,
                                      output logic step_pos,
                                      output logic [DIST_W-1:0] delta,
                                      output logic [DIST_W-1:0] side);
        longint unsigned ipart, frac, mag, span, d, s;
        ipart = pos >> FRAC_BITS;
        frac  = pos & ((64'd1 << FRAC_BITS) - 1);
        mag   = (dir < 0) ? longint'(-dir) : longint'(dir);
        start_cell = (ipart > 255) ? 8'hff : ipart[CELL_W-1:0];
        if (mag == 0) d = 64'hffff_ffff;
        else d = (64'd1 << (2 * FRAC_BITS)) / mag;
        if (d > 64'hffff_ffff) d = 64'hffff_ffff;
        if (dir < 0) begin
            step_pos = 1'b0;
            span = frac;
        end else begin
            step_pos = 1'b1;
            span = (64'd1 << FRAC_BITS) - frac;
        end
        s = (span * d) >> FRAC_BITS;
        if (s > 64'hffff_ffff) s = 64'hffff_ffff;
        delta = d[DIST_W-1:0];
        side  = s[DIST_W-1:0];
    endfunction

    // floor of p / 2^FRAC_BITS, then added to the view component and saturated
    function automatic longint steer(input longint view, input longint plane,
                                     input longint cam);
        longint p, q, r;
        p = plane * cam;
        q = p >>> FRAC_BITS;
        r = view + q;
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r;
    endfunction

    function automatic ray_setup_t cast_column(input logic [COL_W-1:0] col);
        ray_setup_t r;
        longint unsigned w;
        longint cam, rdx, rdy;
        w = 64'(sh_width);
        if (w == 0) w = 1;
        if (w > 64'(MAX_WIDTH)) w = 64'(MAX_WIDTH);
        cam = longint'(((2 * longint'(col)) << FRAC_BITS) / w) - (64'sd1 <<< FRAC_BITS);
        if (cam > (64'sd1 <<< FRAC_BITS)) cam = 64'sd1 <<< FRAC_BITS;
        rdx = steer(longint'(sh_view_x), longint'(sh_plane_x), cam);
        rdy = steer(longint'(sh_view_y), longint'(sh_plane_y), cam);
        r.camera_x  = cam[DIR_W-1:0];
        r.ray_dir_x = rdx[DIR_W-1:0];
        r.ray_dir_y = rdy[DIR_W-1:0];
        walk_axis(rdx, 64'(sh_pos_x), r.cell_x, r.step_x_pos, r.delta_x, r.side_x);
        walk_axis(rdy, 64'(sh_pos_y), r.cell_y, r.step_y_pos, r.delta_y, r.side_y);
        return r;
    endfunction

    // request driver: valid is held until accepted, gaps drawn per request
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_accepted) begin
            // hold current request
        end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            s_valid <= 1'b0;
        end else if (column_queue.size() > 0) begin
            s_valid  <= 1'b1;
            s_column <= column_queue.pop_front();
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // predict at acceptance, with the shadow registers live at that edge
    always @(posedge aclk) begin
        s_accepted <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_rays.push_back(cast_column(s_column));
    end

    // result side stall pattern
    always @(negedge aclk) begin
        int pause;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            pause = recv_wait;
            if (m_accepted)
                pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (pause > 0) begin
                recv_wait <= pause - 1;
                m_ready <= 1'b0;
            end else begin
                recv_wait <= 0;
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        ray_setup_t exp_ray;
        m_accepted <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rays.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected ray setup: %h", got);
            end else begin
                exp_ray = expected_rays.pop_front();
                rays_checked = rays_checked + 1;
                if (got !== exp_ray) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("ray mismatch: cam %0d/%0d dir %0d,%0d / %0d,%0d",
                                 exp_ray.camera_x, got.camera_x, exp_ray.ray_dir_x,
                                 exp_ray.ray_dir_y, got.ray_dir_x, got.ray_dir_y);
                        $display("  cell %0d,%0d / %0d,%0d step %b%b / %b%b",
                                 exp_ray.cell_x, exp_ray.cell_y, got.cell_x, got.cell_y,
                                 exp_ray.step_x_pos, exp_ray.step_y_pos,
                                 got.step_x_pos, got.step_y_pos);
                        $display("  delta %h,%h / %h,%h side %h,%h / %h,%h",
                                 exp_ray.delta_x, exp_ray.delta_y, got.delta_x,
                                 got.delta_y, exp_ray.side_x, exp_ray.side_y,
                                 got.side_x, got.side_y);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_POS_X:   sh_pos_x   = val[POS_W-1:0];
            REG_POS_Y:   sh_pos_y   = val[POS_W-1:0];
            REG_VIEW_X:  sh_view_x  = val[DIR_W-1:0];
            REG_VIEW_Y:  sh_view_y  = val[DIR_W-1:0];
            REG_PLANE_X: sh_plane_x = val[DIR_W-1:0];
            REG_PLANE_Y: sh_plane_y = val[DIR_W-1:0];
            REG_WIDTH:   sh_width   = val[WIDTH_W-1:0];
            default: ;
        endcase
    endtask

    // drain everything in flight, then settle before touching registers
    task automatic drain();
        while (!(column_queue.size() == 0 && !s_valid && expected_rays.size() == 0))
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_camera(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [DIR_W-1:0] vx, input logic [DIR_W-1:0] vy,
                              input logic [DIR_W-1:0] plx, input logic [DIR_W-1:0] ply,
                              input logic [WIDTH_W-1:0] w);
        write_reg(REG_POS_X, px);
        write_reg(REG_POS_Y, py);
        write_reg(REG_VIEW_X, CFG_DAT_W'(vx));
        write_reg(REG_VIEW_Y, CFG_DAT_W'(vy));
        write_reg(REG_PLANE_X, CFG_DAT_W'(plx));
        write_reg(REG_PLANE_Y, CFG_DAT_W'(ply));
        write_reg(REG_WIDTH, CFG_DAT_W'(w));
        configs_used = configs_used + 1;
    endtask

    function automatic logic [DIR_W-1:0] any_dir();
        case ($urandom_range(0, 5))
            0: return DIR_MAX;
            1: return DIR_MIN;
            2: return '0;
            default: return DIR_W'($urandom());
        endcase
    endfunction

    initial begin
        logic [WIDTH_W-1:0] w;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_column  = '0;
        m_ready   = 1'b0;
        send_wait = 0;
        recv_wait = 0;
        mismatches = 0;
        rays_checked = 0;
        configs_used = 1;
        sh_pos_x = '0;  sh_pos_y = '0;
        sh_view_x = RST_VIEW_X; sh_view_y = '0;
        sh_plane_x = '0; sh_plane_y = RST_PLANE_Y;
        sh_width = RST_WIDTH;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: edge columns, centre, columns past the width
        column_queue.push_back(0);
        column_queue.push_back(319);
        column_queue.push_back(320);
        column_queue.push_back(639);
        column_queue.push_back(640);
        column_queue.push_back(4095);
        drain();

        // zero width, full-scale position and directions
        set_camera(24'hffffff, 24'hffffff, DIR_MAX, DIR_MIN, DIR_MIN, DIR_MAX, 13'd0);
        column_queue.push_back(0);
        column_queue.push_back(1);
        column_queue.push_back(4095);
        drain();

        // width above the limit, zero ray components, whole-cell positions
        set_camera(24'h050000, 24'h000000, '0, '0, '0, '0, 13'h1fff);
        column_queue.push_back(0);
        column_queue.push_back(2048);
        column_queue.push_back(4095);
        drain();
        set_camera(24'h0a8000, 24'h7f0001, '0, 18'sd65536, 18'sd65536, '0, 13'd4096);
        column_queue.push_back(2048);
        column_queue.push_back(0);
        column_queue.push_back(4095);
        column_queue.push_back(1);
        column_queue.push_back(2047);
        drain();
        // tiny direction: reciprocal saturates
        set_camera(24'h123456, 24'hfedcba, 18'sd1, -18'sd1, '0, '0, 13'd1);
        column_queue.push_back(0);
        column_queue.push_back(12'haaa);
        column_queue.push_back(12'h555);
        drain();

        // random phases
        for (int phase = 0; phase < 27; phase++) begin
            case ($urandom_range(0, 3))
                0: w = WIDTH_W'($urandom_range(1, 16));
                1: w = WIDTH_W'($urandom());
                default: w = WIDTH_W'($urandom_range(1, 4096));
            endcase
            set_camera(POS_W'($urandom()), POS_W'($urandom()), any_dir(), any_dir(),
                       any_dir(), any_dir(), w);
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(0, 4) == 0)
                    column_queue.push_back(COL_W'($urandom()));
                else
                    column_queue.push_back(COL_W'($urandom_range(0, (w == 0) ? 0 : w - 1)));
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge aclk);
        $display("%0d ray setups checked across %0d camera settings, %0d mismatches",
                 rays_checked, configs_used, mismatches);
        if (mismatches == 0 && expected_rays.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #4ms;
        $display("timeout with %0d rays outstanding", expected_rays.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rcs_pkg.sv
rtl/core/rcs_div.sv
rtl/core/raycast_column_setup_top.sv
tb/raycast_column_setup_top_tb.sv
